FILE: rtl/core/tksb_pkg.sv
// ----------------------------------------------------------------------------
// tksb_pkg: shared types for the top-k score board
// Entry layout, result word layout, command codes and memory control group.
// ----------------------------------------------------------------------------
package tksb_pkg;

  // command codes carried in the input tuser
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // widths fixed by the interface
  localparam int SCORE_W = 16;
  localparam int TAG_W   = 32;
  localparam int LEVEL_W = 2;
  localparam int COUNT_W = 5;
  localparam int RANK_W  = 4;
  localparam int FILL_W  = 5;

  // most entries one read returns
  localparam int MAX_READ = 16;

  // one board entry
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // one result word
  typedef struct packed {
    logic               entry_valid;
    logic               placed;
    logic [RANK_W-1:0]  rank;
    entry_t             entry;
    logic [FILL_W-1:0]  fill;
    logic               last;
  } result_t;

  // board memory port enables
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: rtl/core/tksb_board_mem.sv
// ----------------------------------------------------------------------------
// tksb_board_mem: board entry storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tksb_board_mem
  import tksb_pkg::*;
#(
  parameter int BOARD_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [BOARD_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/tksb_ctrl.sv
// ----------------------------------------------------------------------------
// tksb_ctrl: board sequencer
// Inserts entries by walking up from the bottom of the board, one read and
// one shifted write per cycle, and streams the top entries out for reads.
// ----------------------------------------------------------------------------
module tksb_ctrl
  import tksb_pkg::*;
#(
  parameter int BOARD_DEPTH = 16,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  logic               clk,
  input  logic               rst,
  // item side
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  entry_t             in_entry,
  input  logic [COUNT_W-1:0] in_count,
  // board memory
  output mem_ctl_t           mem_ctl,
  output logic [IDX_W-1:0]   wr_addr,
  output entry_t             wr_data,
  output logic [IDX_W-1:0]   rd_addr,
  input  entry_t             rd_data,
  // result side
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res_out
);

  localparam int NW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BOARD_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOARD_DEPTH - 1);
  localparam logic [NW-1:0]    MAX_N    = NW'(MAX_READ);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FULLCHK = 6'b000010,
    S_SHIFT   = 6'b000100,
    S_PLACE   = 6'b001000,
    S_RD      = 6'b010000,
    S_REPORT  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] n_reg, n_next;
  logic [CNT_W-1:0] iss, iss_next;
  logic             rd_pend, pend_next;
  logic [IDX_W-1:0] rd_rank, rank_next;
  result_t          res, res_next;
  entry_t           cur_entry;

  logic             accept;
  logic [CNT_W-1:0] fill_m1;
  logic [CNT_W-1:0] fill_inc;
  logic [IDX_W+RANK_W-1:0] slot_wide;
  logic [IDX_W+RANK_W-1:0] pend_wide;
  logic [CNT_W+FILL_W-1:0] fill_wide;
  logic [CNT_W+FILL_W-1:0] inc_wide;
  logic [NW-1:0]    cnt_w, fill_w, nmin, nclip;
  logic [CNT_W-1:0] pend_pos;
  logic             stream_last;
  logic             issue, load;
  result_t          res_add, res_empty, res_stream;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign fill_m1  = fill - CNT_W'(1);
  assign fill_inc = (fill == DEPTH_C) ? fill : fill + CNT_W'(1);

  // narrow rank and fill views for the result word
  assign slot_wide = {{RANK_W{1'b0}}, slot};
  assign pend_wide = {{RANK_W{1'b0}}, rd_rank};
  assign fill_wide = {{FILL_W{1'b0}}, fill};
  assign inc_wide  = {{FILL_W{1'b0}}, fill_inc};

  // read length clipped to fill and to the result limit
  assign cnt_w  = NW'(in_count);
  assign fill_w = NW'(fill);
  assign nmin   = (cnt_w < fill_w) ? cnt_w : fill_w;
  assign nclip  = (nmin > MAX_N) ? MAX_N : nmin;

  // streaming read bookkeeping
  assign pend_pos    = CNT_W'(rd_rank) + CNT_W'(1);
  assign stream_last = (pend_pos == n_reg);
  assign load        = rd_pend && res_ready;
  assign issue       = (iss != n_reg) && (!rd_pend || res_ready);

  // candidate result words
  always_comb begin
    res_add             = '0;
    res_add.entry_valid = 1'b1;
    res_add.placed      = 1'b1;
    res_add.rank        = slot_wide[RANK_W-1:0];
    res_add.entry       = cur_entry;
    res_add.fill        = inc_wide[FILL_W-1:0];
    res_add.last        = 1'b1;

    res_empty      = '0;
    res_empty.fill = fill_wide[FILL_W-1:0];
    res_empty.last = 1'b1;

    res_stream             = '0;
    res_stream.entry_valid = 1'b1;
    res_stream.rank        = pend_wide[RANK_W-1:0];
    res_stream.entry       = rd_data;
    res_stream.fill        = fill_wide[FILL_W-1:0];
    res_stream.last        = stream_last;
  end

  // sequencer
  always_comb begin
    state_next = state;
    slot_next  = slot;
    fill_next  = fill;
    n_next     = n_reg;
    iss_next   = iss;
    pend_next  = rd_pend;
    rank_next  = rd_rank;
    res_next   = res;
    mem_ctl    = '0;
    wr_addr    = slot;
    wr_data    = cur_entry;
    rd_addr    = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ADD) begin
            if (fill == '0) begin
              slot_next  = '0;
              state_next = S_PLACE;
            end else if (fill == DEPTH_C) begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = LAST_IDX;
              state_next    = S_FULLCHK;
            end else begin
              slot_next     = fill[IDX_W-1:0];
              mem_ctl.rd_en = 1'b1;
              rd_addr       = fill_m1[IDX_W-1:0];
              state_next    = S_SHIFT;
            end
          end else begin
            n_next    = nclip[CNT_W-1:0];
            iss_next  = '0;
            pend_next = 1'b0;
            if (nclip == '0) begin
              res_next   = res_empty;
              state_next = S_REPORT;
            end else begin
              state_next = S_RD;
            end
          end
        end
      end

      // bottom entry read back: replace it only on a strictly higher score
      S_FULLCHK: begin
        if (cur_entry.score > rd_data.score) begin
          slot_next     = LAST_IDX;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = LAST_IDX - IDX_W'(1);
          state_next    = S_SHIFT;
        end else begin
          res_next   = res_empty;
          state_next = S_REPORT;
        end
      end

      // entry above the slot is in rd_data: stop or move it down
      S_SHIFT: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = slot;
        if (rd_data.score >= cur_entry.score) begin
          wr_data    = cur_entry;
          res_next   = res_add;
          fill_next  = fill_inc;
          state_next = S_REPORT;
        end else begin
          wr_data = rd_data;
          if (slot == IDX_W'(1)) begin
            slot_next  = '0;
            state_next = S_PLACE;
          end else begin
            slot_next     = slot - IDX_W'(1);
            mem_ctl.rd_en = 1'b1;
            rd_addr       = slot - IDX_W'(2);
          end
        end
      end

      // new entry lands at the top slot
      S_PLACE: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = slot;
        wr_data       = cur_entry;
        res_next      = res_add;
        fill_next     = fill_inc;
        state_next    = S_REPORT;
      end

      // one read in flight at most, held in the memory read register
      S_RD: begin
        if (issue) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = iss[IDX_W-1:0];
          iss_next      = iss + CNT_W'(1);
          pend_next     = 1'b1;
          rank_next     = iss[IDX_W-1:0];
        end else if (load) begin
          pend_next = 1'b0;
        end
        if (load && stream_last) begin
          state_next = S_IDLE;
        end
      end

      S_REPORT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result toward the output stage
  assign res_valid = (state == S_REPORT) || ((state == S_RD) && rd_pend);
  assign res_out   = (state == S_RD) ? res_stream : res;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      rd_pend <= 1'b0;
      iss     <= '0;
      n_reg   <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      rd_pend <= pend_next;
      iss     <= iss_next;
      n_reg   <= n_next;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    slot    <= slot_next;
    rd_rank <= rank_next;
    res     <= res_next;
    if (accept) begin
      cur_entry <= in_entry;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("fill count beyond board depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rd_pend)
    else $error("read data left pending in idle");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> iss <= n_reg)
    else $error("more reads issued than requested");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (state == S_SHIFT || state == S_PLACE))
    else $error("board written outside an insert");

  a_fill_steady_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_REPORT) |=> $stable(fill))
    else $error("fill changed while reporting");

endmodule

FILE: rtl/core/tksb_out_stage.sv
// ----------------------------------------------------------------------------
// tksb_out_stage: result output register
// Holds one result word so the sequencer is decoupled from the consumer.
// ----------------------------------------------------------------------------
module tksb_out_stage
  import tksb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign in_ready = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

FILE: rtl/core/top_k_score_board_unit.sv
// ----------------------------------------------------------------------------
// top_k_score_board_unit: top-k score board
// Keeps up to BOARD_DEPTH entries sorted by descending score in a board
// memory; add words insert an entry, read words stream out the top entries.
//
// channel   dir  handshake                   contents
// s_axis    in   s_axis_tvalid/tready        tuser: command; tdata: entry, count
// m_axis    out  m_axis_tvalid/tready        tuser: flags; tdata: result; tlast
//
// add: entries below the new one move down a slot at a time, after a bottom
//   check on a full board, paced by the one read and one write port of the
//   board memory; an add dropped on a full board returns an empty result
// read: one result per cycle while the output register accepts, from the
//   registered read port; a read that returns nothing gives one empty result
// reset clears the fill count and control; board contents stay undefined
// the output register holds a word while m_axis_tready is low; input waits
// until the current word's last result has been handed over
// ----------------------------------------------------------------------------
module top_k_score_board_unit
  import tksb_pkg::*;
#(
  parameter int BOARD_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // new_score, record_tag, level, read_count
  input  logic [0:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // rank, out_score, out_tag, out_level, fill
  output logic [1:0]  m_axis_tuser,  // entry_valid, placed
  output logic        m_axis_tlast
);

  localparam int IDX_W = $clog2(BOARD_DEPTH);
  localparam int CNT_W = $clog2(BOARD_DEPTH + 1);

  entry_t             in_entry;
  logic [COUNT_W-1:0] in_count;
  mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             wr_data;
  entry_t             rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_word;

  // input word unpacking
  assign in_entry.score = s_axis_tdata[15:0];
  assign in_entry.tag   = s_axis_tdata[47:16];
  assign in_entry.level = s_axis_tdata[49:48];
  assign in_count       = s_axis_tdata[54:50];

  tksb_ctrl #(
    .BOARD_DEPTH (BOARD_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser[0]),
    .in_entry  (in_entry),
    .in_count  (in_count),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res)
  );

  tksb_board_mem #(
    .BOARD_DEPTH (BOARD_DEPTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tksb_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  // output word packing
  assign m_axis_tdata = {5'b0, out_word.fill, out_word.entry.level, out_word.entry.tag,
                         out_word.entry.score, out_word.rank};
  assign m_axis_tuser = {out_word.placed, out_word.entry_valid};
  assign m_axis_tlast = out_word.last;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top-k score board stream test
// Drives add and read words into the score board and keeps a mirror of the
// sorted board. The mirror gives the expected result words, and a checker
// compares every word leaving the block field by field. Directed cases cover
// the empty board, ties, extreme scores, level 3, a full board, and clipped
// read counts. Random traffic, long back-pressure and drain pauses follow.
// ----------------------------------------------------------------------------
module testbench
  import tksb_pkg::*;
();

  localparam int BOARD_SIZE = 16;

  // difficulty codes
  localparam logic [LEVEL_W-1:0] LVL_EASY   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HARD   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_SPARE  = 2'd3;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hffff;

  // one input word, unpacked
  typedef struct {
    logic               cmd;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] count;
  } score_cmd_t;

  // one result word, unpacked
  typedef struct {
    logic               entry_valid;
    logic               placed;
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [LEVEL_W-1:0] level;
    logic [FILL_W-1:0]  fill;
    logic               last;
  } board_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // new_score, record_tag, level, read_count
  logic [0:0]  s_axis_tuser = '0;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // rank, out_score, out_tag, out_level, fill
  logic [1:0]  m_axis_tuser;        // entry_valid, placed
  logic        m_axis_tlast;

  // mirror of the board
  logic [SCORE_W-1:0] mirror_score [BOARD_SIZE];
  logic [TAG_W-1:0]   mirror_tag   [BOARD_SIZE];
  logic [LEVEL_W-1:0] mirror_level [BOARD_SIZE];
  int                 mirror_fill = 0;

  board_word_t expected_words [$];

  bit idle_enable  = 1'b1;
  int hold_request = 0;

  int error_count   = 0;
  int words_checked = 0;
  int adds_placed   = 0;
  int adds_dropped  = 0;
  int reads_done    = 0;
  int empty_reads   = 0;

  top_k_score_board_unit #(
    .BOARD_DEPTH(BOARD_SIZE)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  // queue one expected word, carrying the current fill
  function automatic void push_word(logic ev, logic pl, int rank, logic [SCORE_W-1:0] score,
                                    logic [TAG_W-1:0] tag, logic [LEVEL_W-1:0] level,
                                    logic last);
    board_word_t w;
    w.entry_valid = ev;
    w.placed      = pl;
    w.rank        = rank[RANK_W-1:0];
    w.score       = score;
    w.tag         = tag;
    w.level       = level;
    w.fill        = mirror_fill[FILL_W-1:0];
    w.last        = last;
    expected_words.push_back(w);
  endfunction

  // update the board mirror for one accepted word and queue its results
  function automatic void apply_board_command(score_cmd_t c);
    int n;
    int pos;
    if (c.cmd == CMD_ADD) begin
      n = mirror_fill;
      if (n >= BOARD_SIZE) begin
        if (c.score > mirror_score[BOARD_SIZE-1]) begin
          n = BOARD_SIZE - 1;  // bottom entry falls off
        end else begin
          adds_dropped++;
          push_word(1'b0, 1'b0, 0, '0, '0, '0, 1'b1);
          return;
        end
      end
      // new entry goes after every entry of equal score
      pos = 0;
      while (pos < n && mirror_score[pos] >= c.score) pos++;
      for (int i = n; i > pos; i--) begin
        mirror_score[i] = mirror_score[i-1];
        mirror_tag[i]   = mirror_tag[i-1];
        mirror_level[i] = mirror_level[i-1];
      end
      mirror_score[pos] = c.score;
      mirror_tag[pos]   = c.tag;
      mirror_level[pos] = c.level;
      mirror_fill       = n + 1;
      adds_placed++;
      push_word(1'b1, 1'b1, pos, c.score, c.tag, c.level, 1'b1);
    end else begin
      n = c.count;
      if (n > mirror_fill) n = mirror_fill;
      if (n > MAX_READ) n = MAX_READ;
      reads_done++;
      if (n == 0) begin
        empty_reads++;
        push_word(1'b0, 1'b0, 0, '0, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          push_word(1'b1, 1'b0, i, mirror_score[i], mirror_tag[i], mirror_level[i],
                    i == n - 1);
        end
      end
    end
  endfunction

  // add word with random filler in the unused count
  function automatic score_cmd_t add_cmd(int score, logic [TAG_W-1:0] tag,
                                         logic [LEVEL_W-1:0] level);
    score_cmd_t c;
    c.cmd   = CMD_ADD;
    c.score = score[SCORE_W-1:0];
    c.tag   = tag;
    c.level = level;
    c.count = COUNT_W'($urandom_range(0, 31));
    return c;
  endfunction

  // read word with random filler in the entry fields
  function automatic score_cmd_t read_cmd(int count);
    score_cmd_t c;
    c.cmd   = CMD_READ;
    c.score = SCORE_W'($urandom);
    c.tag   = $urandom;
    c.level = LEVEL_W'($urandom_range(0, 3));
    c.count = count[COUNT_W-1:0];
    return c;
  endfunction

  // offer one word, with an optional random gap first, and wait for acceptance
  task automatic send_word(score_cmd_t c);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {1'b0, c.count, c.level, c.tag, c.score};
    do @(posedge clk); while (!s_axis_tready);
    apply_board_command(c);
  endtask

  task automatic release_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // wait until every expected word is out, then cover the longest add
  task automatic wait_for_drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (BOARD_SIZE + 8) @(posedge clk);
  endtask

  // output ready: random stalls and requested long hold-offs
  initial begin : sink_control
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_words
    board_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending: tdata %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        check_field("entry_valid", want.entry_valid, m_axis_tuser[0]);
        check_field("placed", want.placed, m_axis_tuser[1]);
        check_field("rank", want.rank, m_axis_tdata[3:0]);
        check_field("out_score", want.score, m_axis_tdata[19:4]);
        check_field("out_tag", want.tag, m_axis_tdata[51:20]);
        check_field("out_level", want.level, m_axis_tdata[53:52]);
        check_field("fill", want.fill, m_axis_tdata[58:54]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // reads on an empty board, including clipped and zero counts
  task automatic test_empty_board();
    send_word(read_cmd(0));
    send_word(read_cmd(5));
    send_word(read_cmd(31));
  endtask

  // fill the board with extremes, ties and level 3, then read it all
  task automatic test_fill_board();
    int scores [16] = '{0, 65535, 0, 1000, 1000, 500, 65535, 2000,
                        0, 40000, 1000, 7, 30000, 65534, 12345, 1};
    send_word(add_cmd(scores[0], 32'h0000_0000, LVL_EASY));
    send_word(add_cmd(scores[1], 32'hffff_ffff, LVL_HARD));
    send_word(add_cmd(scores[2], 32'h5555_5555, LVL_SPARE));
    for (int i = 3; i < 16; i++) begin
      send_word(add_cmd(scores[i], $urandom, LEVEL_W'(i % 4)));
    end
    send_word(read_cmd(16));
  endtask

  // full board: drop on equal score, bottom replaced by tied scores, top tie, clipped reads
  task automatic test_full_board();
    send_word(add_cmd(0, 32'hdead_beef, LVL_MEDIUM));
    send_word(add_cmd(1, 32'h1234_5678, LVL_EASY));
    send_word(add_cmd(1, 32'h8765_4321, LVL_HARD));
    send_word(add_cmd(SCORE_MAX, 32'haaaa_aaaa, LVL_SPARE));
    send_word(read_cmd(31));
    send_word(read_cmd(0));
  endtask

  // receiver holds off long while words keep coming, so the input stalls
  task automatic test_long_backpressure();
    hold_request = 300;
    send_word(read_cmd(16));
    send_word(read_cmd(16));
    send_word(add_cmd($urandom_range(0, 65535), $urandom, LVL_MEDIUM));
    send_word(read_cmd(20));
    send_word(add_cmd(SCORE_MAX, $urandom, LVL_HARD));
    send_word(read_cmd(16));
  endtask

  // sender pauses until everything has come back, then resumes
  task automatic test_drain_pause();
    send_word(read_cmd(3));
    send_word(add_cmd(40000, $urandom, LVL_EASY));
    release_input();
    wait_for_drain();
    send_word(read_cmd(8));
    send_word(add_cmd(2, $urandom, LVL_HARD));
    send_word(read_cmd(1));
  endtask

  // random mix, biased toward scores near the bottom and existing scores
  function automatic score_cmd_t random_cmd();
    int pick;
    int score;
    pick = $urandom_range(0, 99);
    if (pick < 25) return read_cmd($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 16));
    if (pick < 50 && mirror_fill == BOARD_SIZE) begin
      score = int'(mirror_score[BOARD_SIZE-1]) + $urandom_range(0, 2) - 1;
      if (score < 0) score = 0;
      if (score > 65535) score = 65535;
    end else if (pick < 62 && mirror_fill > 0) begin
      score = mirror_score[$urandom_range(0, mirror_fill - 1)];
    end else if (pick < 70) begin
      score = 65535;
    end else begin
      score = $urandom_range(0, 65535);
    end
    return add_cmd(score, $urandom, LEVEL_W'($urandom_range(0, 3)));
  endfunction

  // random traffic with idle stretches switched on and off
  task automatic test_random_traffic();
    for (int i = 0; i < 270; i++) begin
      idle_enable = ((i / 45) % 3) != 2;
      send_word(random_cmd());
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    idle_enable = 1'b0;
    for (int i = 0; i < 20; i++) send_word(random_cmd());
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_board();
    test_fill_board();
    test_full_board();
    test_long_backpressure();
    test_drain_pause();
    test_random_traffic();
    test_steady_stream();
    release_input();
    wait_for_drain();
    $display("covered %0d adds (%0d placed, %0d dropped), %0d reads (%0d empty)",
             adds_placed + adds_dropped, adds_placed, adds_dropped, reads_done, empty_reads);
    $display("%0d result words checked, %0d mismatches", words_checked, error_count);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
